[hw/rtl/qp2m_pkg.sv]
package qp2m_pkg;

  // Field widths
  localparam int QUAT_W  = 16;
  localparam int TRANS_W = 32;
  localparam int SCALE_W = 24;
  localparam int OUT_W   = 48;

  // Port packing
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 4 * QUAT_W + 3 * TRANS_W + 3 * SCALE_W;
  localparam int NROW       = 3;
  localparam int NCOL       = 4;
  localparam int NLANE      = NROW * NCOL;
  localparam int OUT_DATA_W = NLANE * OUT_W;

  // Internal arithmetic widths
  localparam int PROD_W = 2 * QUAT_W;          // quaternion products
  localparam int ROT_W  = PROD_W + 2;          // rotation entries, Q.28
  localparam int TH_W   = TRANS_W - 15;        // high half of -t, signed
  localparam int TL_W   = 16;                  // low half of -t, unsigned
  localparam int PH_W   = ROT_W + TH_W;        // partial products of -R^T t
  localparam int SUM_W  = PH_W + 2;            // sum of three partial products
  localparam int V_W    = SUM_W + 14;          // -R^T t exact, Q.44
  localparam int RS_W   = ROT_W + SCALE_W + 1; // rotation times scale
  localparam int ROTN_W = ROT_W + 6;           // 32*r + s
  localparam int TRN_W  = V_W + 1;             // V + s*2^11
  localparam int DVD_W  = 54;                  // divider dividend
  localparam int QUO_W  = OUT_W - 1;           // divider quotient bits

  // Modes
  localparam logic [CMD_W-1:0] CMD_FWD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FWD_SCL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INV     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INV_SCL = 2'd3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [OUT_W-1:0] mval_t;

  // Division request: one divisor per row, four dividends per row
  typedef struct packed {
    logic [NROW-1:0][SCALE_W-1:0] dvs;
    logic [NLANE-1:0][DVD_W-1:0]  dvd;
    logic [NLANE-1:0]             neg;
  } div_req_t;

endpackage

[hw/rtl/qp2m_div.sv]
module qp2m_div import qp2m_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  div_req_t               req,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output mval_t [NLANE-1:0]      res,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int OVF_W = DVD_W - QUO_W;

  typedef struct packed {
    logic [NROW-1:0][SCALE_W-1:0] dvs;
    logic [NLANE-1:0]             ovf;
    logic [NLANE-1:0]             neg;
    logic [NLANE-1:0][SCALE_W-1:0] rem;
    logic [NLANE-1:0][QUO_W-1:0]  dq;
  } dstage_t;

  // Flag quotients that cannot fit, load the high dividend bits as remainder
  function automatic dstage_t setup(input div_req_t r);
    dstage_t s;
    logic [SCALE_W-1:0] hi;
    s = '0;
    s.dvs = r.dvs;
    s.neg = r.neg;
    for (int k = 0; k < NLANE; k++) begin
      hi = {{(SCALE_W-OVF_W){1'b0}}, r.dvd[k][DVD_W-1:QUO_W]};
      s.ovf[k] = hi >= r.dvs[k / NCOL];
      s.rem[k] = s.ovf[k] ? '0 : hi;
      s.dq[k]  = r.dvd[k][QUO_W-1:0];
    end
    return s;
  endfunction

  // One restoring step: bring in a dividend bit, shift in a quotient bit
  function automatic dstage_t step(input dstage_t s);
    dstage_t o;
    logic [SCALE_W:0] sh;
    logic [SCALE_W:0] dv;
    logic [SCALE_W:0] df;
    logic ge;
    o = s;
    for (int k = 0; k < NLANE; k++) begin
      sh = {s.rem[k], s.dq[k][QUO_W-1]};
      dv = {1'b0, s.dvs[k / NCOL]};
      df = sh - dv;
      ge = sh >= dv;
      o.rem[k] = ge ? df[SCALE_W-1:0] : sh[SCALE_W-1:0];
      o.dq[k]  = {s.dq[k][QUO_W-2:0], ge};
    end
    return o;
  endfunction

  dstage_t            st   [QUO_W+1];
  logic [SIDE_W-1:0]  side [QUO_W+1];
  logic [QUO_W:0]     vld;
  mval_t [NLANE-1:0]  fin;

  // Undo the magnitude trick: floor of a negative quotient is the complement
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      if (st[QUO_W].ovf[k]) begin
        fin[k] = st[QUO_W].neg[k] ? OUT_MIN : OUT_MAX;
      end else if (st[QUO_W].neg[k]) begin
        fin[k] = ~{{(OUT_W-QUO_W){1'b0}}, st[QUO_W].dq[k]};
      end else begin
        fin[k] = {{(OUT_W-QUO_W){1'b0}}, st[QUO_W].dq[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QUO_W-1:0], in_valid};
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]   <= setup(req);
      side[0] <= in_side;
      for (int k = 1; k <= QUO_W; k++) begin
        st[k]   <= step(st[k-1]);
        side[k] <= side[k-1];
      end
      res      <= fin;
      out_side <= side[QUO_W];
    end
  end

endmodule

[hw/rtl/quat_pose_to_matrix_core.sv]
// Pose to 3x4 transform. Each request carries a quaternion (Q1.14), a
// translation (Q15.16) and a per-axis scale (unsigned Q8.16); the mode in
// tuser selects [R|t], [R*diag(s)|t], [R^T|-R^T t] or that inverse with row i
// divided by scale i. The twelve Q31.16 results come out on m_tdata, rounded
// once to nearest (ties up) and saturated to 48 bits; a zero scale in the
// scaled inverse gives the saturated sign of each entry. The block takes one
// request per cycle while not stalled. Six arithmetic stages (products,
// rotation, scale and translation products, sums, -R^T t, rounding and
// dividend setup) feed a 47-stage restoring divider, one quotient bit
// per stage, plus its setup and sign-fix registers. All modes pass through the
// same depth, so results leave in request order. A stall on the master side
// holds the whole pipeline; s_tready is low only while a result waits there.
module quat_pose_to_matrix_core import qp2m_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // quat_x, quat_y, quat_z, quat_w, trans_x, trans_y, trans_z,
  // scale_x, scale_y, scale_z
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int SIDE_W  = NROW + NLANE * OUT_W;
  localparam int RRND_W  = ROT_W - 12;
  localparam int SRND_W  = RS_W - 28;

  localparam logic signed [ROT_W-1:0] ROT_HALF = ROT_W'(2048);
  localparam logic signed [RS_W-1:0]  RS_HALF  = RS_W'(1) << 27;
  localparam logic signed [V_W-1:0]   V_HALF   = V_W'(1) << 27;

  function automatic mval_t sat_sign(input logic signed [V_W-1:0] v);
    mval_t o;
    if (v > 0) begin
      o = OUT_MAX;
    end else if (v < 0) begin
      o = OUT_MIN;
    end else begin
      o = '0;
    end
    return o;
  endfunction

  logic en;

  // Advance everything unless a finished result is held on the master side
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input fields
  logic signed [QUAT_W-1:0]  qx, qy, qz, qw;
  logic signed [TRANS_W-1:0] tin [3];
  logic [SCALE_W-1:0]        sin [3];

  assign qx = s_tdata[0*QUAT_W +: QUAT_W];
  assign qy = s_tdata[1*QUAT_W +: QUAT_W];
  assign qz = s_tdata[2*QUAT_W +: QUAT_W];
  assign qw = s_tdata[3*QUAT_W +: QUAT_W];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tin[i] = s_tdata[4*QUAT_W + i*TRANS_W +: TRANS_W];
      sin[i] = s_tdata[4*QUAT_W + 3*TRANS_W + i*SCALE_W +: SCALE_W];
    end
  end

  // Stage 1: quaternion products
  logic                      p1_vld;
  logic [CMD_W-1:0]          p1_cmd;
  logic signed [PROD_W-1:0]  p1_xx, p1_yy, p1_zz, p1_ww, p1_xy, p1_xz, p1_xw;
  logic signed [PROD_W-1:0]  p1_yz, p1_yw, p1_zw;
  logic signed [TRANS_W-1:0] p1_t [3];
  logic [SCALE_W-1:0]        p1_s [3];

  // Stage 2: rotation entries, -t split into halves
  logic                      p2_vld;
  logic [CMD_W-1:0]          p2_cmd;
  logic signed [ROT_W-1:0]   p2_r [3][3];
  logic signed [TH_W-1:0]    p2_th [3];
  logic [TL_W-1:0]           p2_tl [3];
  logic signed [TRANS_W-1:0] p2_t [3];
  logic [SCALE_W-1:0]        p2_s [3];

  // Stage 3: scaled rotation, partial products of -R^T t
  logic                      p3_vld;
  logic [CMD_W-1:0]          p3_cmd;
  logic signed [RS_W-1:0]    p3_rs [3][3];
  logic signed [PH_W-1:0]    p3_ph [3][3];
  logic signed [PH_W-1:0]    p3_pl [3][3];
  logic signed [ROT_W-1:0]   p3_r [3][3];
  logic signed [TRANS_W-1:0] p3_t [3];
  logic [SCALE_W-1:0]        p3_s [3];

  // Stage 4: sums and rounding of the direct entries
  logic                      p4_vld;
  logic [CMD_W-1:0]          p4_cmd;
  logic signed [SUM_W-1:0]   p4_sh [3];
  logic signed [SUM_W-1:0]   p4_sl [3];
  logic signed [SRND_W-1:0]  p4_srnd [3][3];
  logic signed [RRND_W-1:0]  p4_rrnd [3][3];
  logic signed [ROT_W-1:0]   p4_r [3][3];
  logic signed [TRANS_W-1:0] p4_t [3];
  logic [SCALE_W-1:0]        p4_s [3];

  // Stage 5: -R^T t exact
  logic                      p5_vld;
  logic [CMD_W-1:0]          p5_cmd;
  logic signed [V_W-1:0]     p5_v [3];
  logic signed [SRND_W-1:0]  p5_srnd [3][3];
  logic signed [RRND_W-1:0]  p5_rrnd [3][3];
  logic signed [ROT_W-1:0]   p5_r [3][3];
  logic signed [TRANS_W-1:0] p5_t [3];
  logic [SCALE_W-1:0]        p5_s [3];

  // Stage 6: direct results and divider requests
  logic                      p6_vld;
  div_req_t                  p6_req;
  logic [SIDE_W-1:0]         p6_side;

  logic [33-1:0] nt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nt[i] = -{p1_t[i][TRANS_W-1], p1_t[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
      p6_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= s_tvalid;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
      p6_vld <= p5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1
      p1_cmd <= s_tuser;
      p1_xx  <= qx * qx;
      p1_yy  <= qy * qy;
      p1_zz  <= qz * qz;
      p1_ww  <= qw * qw;
      p1_xy  <= qx * qy;
      p1_xz  <= qx * qz;
      p1_xw  <= qx * qw;
      p1_yz  <= qy * qz;
      p1_yw  <= qy * qw;
      p1_zw  <= qz * qw;
      for (int i = 0; i < 3; i++) begin
        p1_t[i] <= tin[i];
        p1_s[i] <= sin[i];
      end

      // Stage 2
      p2_cmd     <= p1_cmd;
      p2_r[0][0] <= ROT_W'(p1_ww) + ROT_W'(p1_xx) - ROT_W'(p1_yy) - ROT_W'(p1_zz);
      p2_r[0][1] <= (ROT_W'(p1_xy) - ROT_W'(p1_zw)) <<< 1;
      p2_r[0][2] <= (ROT_W'(p1_xz) + ROT_W'(p1_yw)) <<< 1;
      p2_r[1][0] <= (ROT_W'(p1_xy) + ROT_W'(p1_zw)) <<< 1;
      p2_r[1][1] <= ROT_W'(p1_ww) - ROT_W'(p1_xx) + ROT_W'(p1_yy) - ROT_W'(p1_zz);
      p2_r[1][2] <= (ROT_W'(p1_yz) - ROT_W'(p1_xw)) <<< 1;
      p2_r[2][0] <= (ROT_W'(p1_xz) - ROT_W'(p1_yw)) <<< 1;
      p2_r[2][1] <= (ROT_W'(p1_yz) + ROT_W'(p1_xw)) <<< 1;
      p2_r[2][2] <= ROT_W'(p1_ww) - ROT_W'(p1_xx) - ROT_W'(p1_yy) + ROT_W'(p1_zz);
      for (int i = 0; i < 3; i++) begin
        p2_th[i] <= nt[i][32:TL_W];
        p2_tl[i] <= nt[i][TL_W-1:0];
        p2_t[i]  <= p1_t[i];
        p2_s[i]  <= p1_s[i];
      end

      // Stage 3: row i of the inverse uses column i of R
      p3_cmd <= p2_cmd;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p3_rs[i][j] <= p2_r[i][j] * $signed({1'b0, p2_s[j]});
          p3_ph[i][j] <= p2_r[j][i] * p2_th[j];
          p3_pl[i][j] <= p2_r[j][i] * $signed({1'b0, p2_tl[j]});
          p3_r[i][j]  <= p2_r[i][j];
        end
        p3_t[i] <= p2_t[i];
        p3_s[i] <= p2_s[i];
      end

      // Stage 4
      p4_cmd <= p3_cmd;
      for (int i = 0; i < 3; i++) begin
        p4_sh[i] <= SUM_W'(p3_ph[i][0]) + SUM_W'(p3_ph[i][1]) + SUM_W'(p3_ph[i][2]);
        p4_sl[i] <= SUM_W'(p3_pl[i][0]) + SUM_W'(p3_pl[i][1]) + SUM_W'(p3_pl[i][2]);
        for (int j = 0; j < 3; j++) begin
          p4_srnd[i][j] <= SRND_W'((p3_rs[i][j] + RS_HALF) >>> 28);
          p4_rrnd[i][j] <= RRND_W'((p3_r[i][j] + ROT_HALF) >>> 12);
          p4_r[i][j]    <= p3_r[i][j];
        end
        p4_t[i] <= p3_t[i];
        p4_s[i] <= p3_s[i];
      end

      // Stage 5
      p5_cmd <= p4_cmd;
      for (int i = 0; i < 3; i++) begin
        p5_v[i] <= (V_W'(p4_sh[i]) <<< TL_W) + V_W'(p4_sl[i]);
        for (int j = 0; j < 3; j++) begin
          p5_srnd[i][j] <= p4_srnd[i][j];
          p5_rrnd[i][j] <= p4_rrnd[i][j];
          p5_r[i][j]    <= p4_r[i][j];
        end
        p5_t[i] <= p4_t[i];
        p5_s[i] <= p4_s[i];
      end
    end
  end

  // Stage 6 logic
  mval_t [NLANE-1:0]   pay;
  logic [NROW-1:0]     use_div;
  div_req_t            req;
  logic [ROTN_W-1:0]   rn, rm;
  logic [TRN_W-1:0]    tn, tm;

  always_comb begin
    req = '0;
    rn  = '0;
    rm  = '0;
    tn  = '0;
    tm  = '0;
    for (int i = 0; i < 3; i++) begin
      req.dvs[i] = p5_s[i];
      use_div[i] = (p5_cmd == CMD_INV_SCL) && (p5_s[i] != '0);
      for (int j = 0; j < 3; j++) begin
        case (p5_cmd)
          CMD_FWD:     pay[i*NCOL+j] = OUT_W'(p5_rrnd[i][j]);
          CMD_FWD_SCL: pay[i*NCOL+j] = OUT_W'(p5_srnd[i][j]);
          CMD_INV:     pay[i*NCOL+j] = OUT_W'(p5_rrnd[j][i]);
          default:     pay[i*NCOL+j] = sat_sign(V_W'(p5_r[j][i]));
        endcase
        // floor((32r + s) / 2s) on the magnitude: halve, then divide by s
        rn = (ROTN_W'(p5_r[j][i]) <<< 5) + ROTN_W'({1'b0, p5_s[i]});
        rm = rn[ROTN_W-1] ? ~rn : rn;
        req.neg[i*NCOL+j] = rn[ROTN_W-1];
        req.dvd[i*NCOL+j] = DVD_W'(rm[ROTN_W-1:1]);
      end
      case (p5_cmd)
        CMD_FWD, CMD_FWD_SCL: pay[i*NCOL+3] = OUT_W'(p5_t[i]);
        CMD_INV:              pay[i*NCOL+3] = OUT_W'((p5_v[i] + V_HALF) >>> 28);
        default:              pay[i*NCOL+3] = sat_sign(p5_v[i]);
      endcase
      // floor((V + s*2^11) / (s*2^12)): drop twelve bits, then divide by s
      tn = TRN_W'(p5_v[i]) + (TRN_W'({1'b0, p5_s[i]}) << 11);
      tm = tn[TRN_W-1] ? ~tn : tn;
      req.neg[i*NCOL+3] = tn[TRN_W-1];
      req.dvd[i*NCOL+3] = tm[DVD_W+11:12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_req  <= req;
      p6_side <= {use_div, pay};
    end
  end

  // Divider pipeline, direct results ride along as side data
  logic               d_vld;
  mval_t [NLANE-1:0]  d_res;
  logic [SIDE_W-1:0]  d_side;
  logic [NROW-1:0]    d_use;
  mval_t [NLANE-1:0]  d_pay;

  qp2m_div #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p6_vld),
    .req       (p6_req),
    .in_side   (p6_side),
    .out_valid (d_vld),
    .res       (d_res),
    .out_side  (d_side)
  );

  assign d_use    = d_side[SIDE_W-1 -: NROW];
  assign d_pay    = d_side[NLANE*OUT_W-1:0];
  assign m_tvalid = d_vld;

  // Pick the quotient for scaled inverse rows with a nonzero scale
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      m_tdata[k*OUT_W +: OUT_W] = d_use[k / NCOL] ? d_res[k] : d_pay[k];
    end
  end

endmodule

[sim/qp2m_checker.sv]
`timescale 1ns / 100ps

module qp2m_checker import qp2m_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    fail_count,
  output int                    pending,
  output int                    matched
);

  logic [OUT_DATA_W-1:0] matrix_q[$];

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp48(longint v);
    longint hi, lo;
    hi = longint'(OUT_MAX);
    lo = longint'(OUT_MIN);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint sign_rail(longint v);
    if (v > 0) return longint'(OUT_MAX);
    if (v < 0) return longint'(OUT_MIN);
    return 0;
  endfunction

  // Twelve Q31.16 entries of the transform for one pose
  function automatic logic [OUT_DATA_W-1:0] pose_matrix(logic [CMD_W-1:0] mode,
                                                        logic [IN_DATA_W-1:0] d);
    longint x, y, z, w, t[3], s[3], r[3][3], m[3][4];
    longint sh, sl, fl, nt, tl, th, a, b, v, a2, b2, e, c;
    logic [OUT_DATA_W-1:0] res;
    int i, j, k;
    x = longint'($signed(d[0 +: 16]));
    y = longint'($signed(d[16 +: 16]));
    z = longint'($signed(d[32 +: 16]));
    w = longint'($signed(d[48 +: 16]));
    for (i = 0; i < 3; i++) begin
      t[i] = longint'($signed(d[64 + i*32 +: 32]));
      s[i] = longint'({40'd0, d[160 + i*24 +: 24]});
    end
    r[0][0] = w*w + x*x - y*y - z*z;
    r[0][1] = 2 * (x*y - z*w);
    r[0][2] = 2 * (x*z + y*w);
    r[1][0] = 2 * (x*y + z*w);
    r[1][1] = w*w - x*x + y*y - z*z;
    r[1][2] = 2 * (y*z - x*w);
    r[2][0] = 2 * (x*z - y*w);
    r[2][1] = 2 * (y*z + x*w);
    r[2][2] = w*w - x*x - y*y + z*z;
    for (i = 0; i < 3; i++) begin
      if (mode == CMD_FWD || mode == CMD_FWD_SCL) begin
        for (j = 0; j < 3; j++)
          if (mode == CMD_FWD) m[i][j] = floor_div(r[i][j] + 2048, 4096);
          else m[i][j] = floor_div(r[i][j] * s[j] + (64'sd1 <<< 27), 64'sd1 <<< 28);
        m[i][3] = t[i];
      end else begin
        // exact -(column i of R) . t, split as a*2^16 + b
        sh = 0;
        sl = 0;
        for (k = 0; k < 3; k++) begin
          c  = r[k][i];
          nt = -t[k];
          tl = nt & 64'hFFFF;
          th = (nt - tl) / 65536;
          sh += c * th;
          sl += c * tl;
        end
        fl = floor_div(sl, 65536);
        a  = sh + fl;
        b  = sl - fl * 65536;
        if (mode == CMD_INV) begin
          for (j = 0; j < 3; j++) m[i][j] = floor_div(r[j][i] + 2048, 4096);
          m[i][3] = floor_div(a + 2048, 4096);
        end else if (s[i] == 0) begin
          // zero scale: each entry goes to the rail of its sign
          for (j = 0; j < 3; j++) m[i][j] = sign_rail(r[j][i]);
          m[i][3] = (a < 0) ? longint'(OUT_MIN) :
                    ((a == 0 && b == 0) ? 0 : longint'(OUT_MAX));
        end else begin
          for (j = 0; j < 3; j++) m[i][j] = floor_div(32 * r[j][i] + s[i], 2 * s[i]);
          v  = b + s[i] * 2048;
          a2 = a + v / 65536;
          b2 = v % 65536;
          e  = a2 * 16 + b2 / 4096;
          m[i][3] = floor_div(e, s[i]);
        end
      end
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 4; j++) begin
        v = clamp48(m[i][j]);
        res[(i*4 + j)*OUT_W +: OUT_W] = v[OUT_W-1:0];
      end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    int errs;
    errs = 0;
    if (rst) begin
      matrix_q.delete();
      fail_count <= 0;
      matched    <= 0;
    end else begin
      if (s_tvalid && s_tready) matrix_q.push_back(pose_matrix(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected matrix %h", $time, m_tdata);
          errs = errs + 1;
        end else begin
          want = matrix_q.pop_front();
          matched <= matched + 1;
          for (int k = 0; k < NLANE; k++)
            if (m_tdata[k*OUT_W +: OUT_W] !== want[k*OUT_W +: OUT_W]) begin
              $display("%0t: m%0d%0d expected %h actual %h", $time, k / 4, k % 4,
                       want[k*OUT_W +: OUT_W], m_tdata[k*OUT_W +: OUT_W]);
              errs = errs + 1;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= matrix_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import qp2m_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 460;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // quat_x..w, trans_x..z, scale_x..z
  logic [CMD_W-1:0]      s_tuser = CMD_FWD;  // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count, pending, matched;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int cycles = 0;

  quat_pose_to_matrix_core uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  qp2m_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending, .matched
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request; hold it until the block takes it
  task automatic send(logic [1:0] cmd, logic [15:0] qx, logic [15:0] qy,
                      logic [15:0] qz, logic [15:0] qw, logic [31:0] tx,
                      logic [31:0] ty, logic [31:0] tz, logic [23:0] sx,
                      logic [23:0] sy, logic [23:0] sz);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {sz, sy, sx, tz, ty, tx, qw, qz, qy, qx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_quat(int style);
    logic [15:0] corner[5] = '{16'h8000, 16'hC000, 16'h0000, 16'h4000, 16'h7FFF};
    case (style)
      0: return 16'($signed($urandom_range(32768)) - 16384);
      1: return 16'($urandom);
      default: return corner[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [31:0] pick_trans();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 32'($signed($urandom_range(2097152)) - 1048576);
    if (sel < 9) return $urandom;
    return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
  endfunction

  function automatic logic [23:0] pick_scale();
    int sel;
    sel = $urandom_range(19);
    if (sel < 12) return 24'($urandom_range(1 << 18, 1 << 14));
    if (sel < 17) return 24'($urandom);
    if (sel < 19) return 24'($urandom_range(255));
    return 24'd0;
  endfunction

  task automatic send_random();
    int style;
    style = ($urandom_range(9) < 5) ? 0 : (($urandom_range(9) < 6) ? 1 : 2);
    send(2'($urandom_range(3)), pick_quat(style), pick_quat(style), pick_quat(style),
         pick_quat(style), pick_trans(), pick_trans(), pick_trans(),
         pick_scale(), pick_scale(), pick_scale());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_tx[4] = '{0, 79, 0, 34};
    int idle_rx[4] = '{0, 0, 79, 34};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity and corner quaternions in every mode
    for (int c = 0; c < 4; c++) begin
      send(2'(c), 16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h00010000,
           32'hFFFF0000, 32'h00000001, 24'h010000, 24'h010000, 24'h010000);
      send(2'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7FFFFFFF,
           32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 24'h000001, 24'h800000);
      send(2'(c), 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 32'h80000000,
           32'h80000000, 32'h80000000, 24'h000001, 24'hFFFFFF, 24'h000001);
    end
    // Zero scale: scaled inverse goes to the rails, scaled forward zeroes two columns
    send(CMD_INV_SCL, 16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 32'h00050000,
         32'hFFF00000, 32'h00000000, 24'h000000, 24'h000000, 24'h000000);
    send(CMD_INV_SCL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000,
         32'h00000000, 32'h00000000, 24'h000000, 24'h010000, 24'h000000);
    send(CMD_INV_SCL, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h00000001,
         32'hFFFFFFFF, 32'h00000000, 24'h000000, 24'h000000, 24'h000000);
    send(CMD_FWD_SCL, 16'h1000, 16'h2000, 16'h3000, 16'h0800, 32'h12345678,
         32'h9ABCDEF0, 32'h0F0F0F0F, 24'h000000, 24'h020000, 24'h000000);
    // Non-unit quaternion with the largest positive components
    send(CMD_INV, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF,
         32'h00000001, 32'h55555555, 24'hAAAAAA, 24'h555555, 24'hFFFFFF);
    send(CMD_INV_SCL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF,
         32'h7FFFFFFF, 32'h7FFFFFFF, 24'h000001, 24'h000001, 24'h000001);
    drain();

    // Random phases with different idling on each side
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = idle_tx[p];
      rx_stall_pct = idle_rx[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while requests keep coming, so the pipe fills
        if (p == 0 && n == 100) rx_hold_req++;
        send_random();
      end
      drain();
    end

    repeat (70) @(posedge clk);
    $display("Checked %0d pose matrices over all four modes, with corner, zero-scale",
             matched);
    $display("and non-unit poses, under four idle/stall mixes and one long hold-off.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
